[rtl/mvtpc_pkg.sv]
// Package for the six-voice tone period calculator.
// Holds field widths, register codes, reset values and the payload structs.
// No dependencies.
package mvtpc_pkg;

    localparam int VOICE_COUNT = 6;

    localparam int CLK_W = 27;
    localparam int F_W   = 16;
    localparam int CMP_W = 15;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLK_HZ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ = 2'd2;

    localparam logic [CLK_W-1:0] RST_CLK_HZ   = 27'd1000000;
    localparam logic [F_W-1:0]   RST_MIN_FREQ = 16'd27;
    localparam logic [F_W-1:0]   RST_MAX_FREQ = 16'd20000;

    // one quotient bit per step
    localparam int DIV_STEPS = CLK_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    typedef struct packed {
        logic           mode;
        logic [F_W-1:0] freq_1;
        logic [F_W-1:0] freq_2;
        logic [F_W-1:0] freq_3;
        logic [F_W-1:0] freq_4;
        logic [F_W-1:0] freq_5;
        logic [F_W-1:0] freq_6;
    } t_in_item;

    typedef struct packed {
        logic [F_W-1:0]   period_1;
        logic [F_W-1:0]   period_2;
        logic [F_W-1:0]   period_3;
        logic [F_W-1:0]   period_4;
        logic [F_W-1:0]   period_5;
        logic [F_W-1:0]   period_6;
        logic [CMP_W-1:0] compare_1;
        logic [CMP_W-1:0] compare_2;
        logic [CMP_W-1:0] compare_3;
        logic [CMP_W-1:0] compare_4;
        logic [CMP_W-1:0] compare_5;
        logic [CMP_W-1:0] compare_6;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic step;
    } t_lane_ctl;

endpackage

[rtl/mvtpc_lane.sv]
// One voice lane: range check and a bit-serial restoring divider
// computing counter_clock_hz / freq, then the saturated period.
// Depends on mvtpc_pkg.
module mvtpc_lane
    import mvtpc_pkg::*;
(
    input  logic             i_clk,
    input  t_lane_ctl        i_ctl,
    input  logic             i_mode,
    input  logic [F_W-1:0]   i_freq,
    input  logic [CLK_W-1:0] i_clk_hz,
    input  logic [F_W-1:0]   i_min_freq,
    input  logic [F_W-1:0]   i_max_freq,
    output logic             o_sounds,
    output logic [F_W-1:0]   o_period
);

    logic [CLK_W-1:0] r_quo, n_quo;
    logic [F_W-1:0]   r_rem, n_rem;
    logic [F_W-1:0]   r_div;
    logic             r_sounds;

    logic [F_W:0]     w_shift;
    logic [F_W:0]     w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[CLK_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        if (i_ctl.load) begin
            n_quo = i_clk_hz;
            n_rem = '0;
        end else if (i_ctl.step) begin
            n_quo = {r_quo[CLK_W-2:0], w_ge};
            // remainder stays below the divisor, so it fits in F_W bits
            n_rem = w_ge ? w_diff[F_W-1:0] : w_shift[F_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_ctl.load) begin
            r_div    <= i_freq;
            r_sounds <= !i_mode && (i_freq != '0) && (i_freq >= i_min_freq)
                        && (i_freq <= i_max_freq);
        end
    end

    // quotient minus one, clamped at zero and at the 16-bit maximum
    always_comb begin
        priority if (r_quo == '0) begin
            o_period = '0;
        end else if (r_quo > CLK_W'(65536)) begin
            o_period = '1;
        end else begin
            o_period = F_W'(r_quo - CLK_W'(1));
        end
    end

    assign o_sounds = r_sounds;

endmodule

[rtl/mvtpc_merge.sv]
// Merge stage: keeps the stored voice periods, combines the lane results
// into one output request and holds it in the output register.
// Depends on mvtpc_pkg.
module mvtpc_merge
    import mvtpc_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_commit,
    input  logic [VOICE_COUNT-1:0]            i_sounds,
    input  logic [VOICE_COUNT-1:0][F_W-1:0]   i_period,
    output logic                              o_can_take,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output t_out_item                         o_out_item
);

    logic [VOICE_COUNT-1:0][F_W-1:0]   r_store;
    logic [VOICE_COUNT-1:0][F_W-1:0]   r_out_period;
    logic [VOICE_COUNT-1:0][CMP_W-1:0] r_out_compare;
    logic                              r_out_valid;

    assign o_can_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_commit) begin
                r_out_valid <= 1'b1;
                for (int i = 0; i < VOICE_COUNT; i++) begin
                    if (i_sounds[i]) begin
                        r_store[i] <= i_period[i];
                    end
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // silent voices keep their stored period and drop the compare to zero
    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            for (int i = 0; i < VOICE_COUNT; i++) begin
                r_out_period[i]  <= i_sounds[i] ? i_period[i] : r_store[i];
                r_out_compare[i] <= i_sounds[i] ? i_period[i][F_W-1:1] : '0;
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_item.period_1  = r_out_period[0];
    assign o_out_item.period_2  = r_out_period[1];
    assign o_out_item.period_3  = r_out_period[2];
    assign o_out_item.period_4  = r_out_period[3];
    assign o_out_item.period_5  = r_out_period[4];
    assign o_out_item.period_6  = r_out_period[5];
    assign o_out_item.compare_1 = r_out_compare[0];
    assign o_out_item.compare_2 = r_out_compare[1];
    assign o_out_item.compare_3 = r_out_compare[2];
    assign o_out_item.compare_4 = r_out_compare[3];
    assign o_out_item.compare_5 = r_out_compare[4];
    assign o_out_item.compare_6 = r_out_compare[5];

endmodule

[rtl/multi_voice_tone_period_calc.sv]
// Top level of the six-voice tone period calculator: configuration
// registers, step sequencer, six divider lanes and the merge stage.
// Depends on mvtpc_pkg, mvtpc_lane and mvtpc_merge.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------
//  in      | request   | i_in_valid / o_in_stall  | i_in_item  (t_in_item)
//  out     | result    | o_out_valid / i_out_stall| o_out_item (t_out_item)
//  cfg     | write     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// Each request runs from acceptance to a valid result in this order: the accepting
// edge loads every lane, then 27 divider steps (one quotient bit per cycle in
// every lane, set by the 27-bit counter clock), then one commit into the output
// register, which waits while a stalled result is held. The next request is
// taken in the cycle after the commit. All six lanes divide at once; one request
// is in work at a time. A result waiting under i_out_stall does not block the next
// request; only its commit waits. Reset is synchronous: config returns to its
// reset values and stored periods clear to zero.
module multi_voice_tone_period_calc
    import mvtpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CLK_W-1:0]     i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CLK_W-1:0]  r_clk_hz;
    logic [F_W-1:0]    r_min_freq;
    logic [F_W-1:0]    r_max_freq;

    logic                            w_accept;
    logic                            w_commit;
    logic                            w_can_take;
    t_lane_ctl                       w_ctl;
    logic [VOICE_COUNT-1:0][F_W-1:0] w_freq;
    logic [VOICE_COUNT-1:0][F_W-1:0] w_period;
    logic [VOICE_COUNT-1:0]          w_sounds;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_commit    = (r_state == ST_DONE) && w_can_take;

    assign w_ctl.load = w_accept;
    assign w_ctl.step = (r_state == ST_DIV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz   <= RST_CLK_HZ;
            r_min_freq <= RST_MIN_FREQ;
            r_max_freq <= RST_MAX_FREQ;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CLK_HZ:   r_clk_hz   <= i_cfg_data;
                CFG_MIN_FREQ: r_min_freq <= i_cfg_data[F_W-1:0];
                CFG_MAX_FREQ: r_max_freq <= i_cfg_data[F_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_DIV;
                    n_step  = '0;
                end
            end
            ST_DIV: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign w_freq[0] = i_in_item.freq_1;
    assign w_freq[1] = i_in_item.freq_2;
    assign w_freq[2] = i_in_item.freq_3;
    assign w_freq[3] = i_in_item.freq_4;
    assign w_freq[4] = i_in_item.freq_5;
    assign w_freq[5] = i_in_item.freq_6;

    for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_lane
        mvtpc_lane u_lane (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_mode     (i_in_item.mode),
            .i_freq     (w_freq[g]),
            .i_clk_hz   (r_clk_hz),
            .i_min_freq (r_min_freq),
            .i_max_freq (r_max_freq),
            .o_sounds   (w_sounds[g]),
            .o_period   (w_period[g])
        );
    end

    mvtpc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (w_commit),
        .i_sounds    (w_sounds),
        .i_period    (w_period),
        .o_can_take  (w_can_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/mvtpc_checker.sv]
// Port-level checker for the tone period calculator, bound to the top level.
// Depends on mvtpc_pkg.
module mvtpc_checker
    import mvtpc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped while stalled");

    a_out_item_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled result changed");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while one is in work");

    a_half_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_item.compare_1 == '0 || o_out_item.compare_1 == o_out_item.period_1[15:1])
         && (o_out_item.compare_2 == '0 || o_out_item.compare_2 == o_out_item.period_2[15:1])
         && (o_out_item.compare_3 == '0 || o_out_item.compare_3 == o_out_item.period_3[15:1])
         && (o_out_item.compare_4 == '0 || o_out_item.compare_4 == o_out_item.period_4[15:1])
         && (o_out_item.compare_5 == '0 || o_out_item.compare_5 == o_out_item.period_5[15:1])
         && (o_out_item.compare_6 == '0 || o_out_item.compare_6 == o_out_item.period_6[15:1]))
        else $error("compare is neither zero nor half the period");

endmodule

bind multi_voice_tone_period_calc mvtpc_checker u_mvtpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
